### rtl/core/tga_pkg.sv
`timescale 1ns / 1ps
// Package for the Targa byte-stream decoder: decoder phases, result kinds,
// header offsets and the result record. It depends on nothing else.
package tga_pkg;

  // Header layout and accepted formats.
  localparam int unsigned HdrLen = 18;
  localparam int unsigned HdrIdxW = $clog2(HdrLen);

  localparam logic [HdrIdxW-1:0] HDR_ID_LEN    = HdrIdxW'(0);
  localparam logic [HdrIdxW-1:0] HDR_TYPE      = HdrIdxW'(2);
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_LO  = HdrIdxW'(12);
  localparam logic [HdrIdxW-1:0] HDR_WIDTH_HI  = HdrIdxW'(13);
  localparam logic [HdrIdxW-1:0] HDR_HEIGHT_LO = HdrIdxW'(14);
  localparam logic [HdrIdxW-1:0] HDR_HEIGHT_HI = HdrIdxW'(15);
  localparam logic [HdrIdxW-1:0] HDR_DEPTH     = HdrIdxW'(16);
  localparam logic [HdrIdxW-1:0] HDR_LAST      = HdrIdxW'(HdrLen - 1);

  localparam logic [7:0] TYPE_TRUE_COLOUR = 8'd2;
  localparam logic [7:0] TYPE_MONO        = 8'd3;
  localparam logic [7:0] TYPE_RLE_COLOUR  = 8'd10;

  localparam logic [7:0] DEPTH_8  = 8'd8;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  localparam logic [7:0] PKT_RUN_MASK   = 8'h80;
  localparam logic [7:0] PKT_COUNT_MASK = 8'h7F;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_IDSKIP  = 3'd1,
    PH_RAW     = 3'd2,
    PH_PKTHDR  = 3'd3,
    PH_PKTDATA = 3'd4,
    PH_DONE    = 3'd5,
    PH_ERROR   = 3'd6
  } phase_e;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_PIXEL     = 3'd1,
    KIND_BAD_TYPE  = 3'd2,
    KIND_BAD_DEPTH = 3'd3,
    KIND_OVERRUN   = 3'd4,
    KIND_TRUNCATED = 3'd5
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] pixel_word;
    logic [7:0]  repeat_count;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  component_count;
    logic        last_pixel;
  } result_t;

endpackage

### rtl/core/tga_image_decoder.sv
`timescale 1ns / 1ps
// Targa image decoder: header parse, ID skip, raw and RLE pixel decode,
// with a two-entry result buffer. Depends on tga_pkg.
//
// Usage. Bytes of a Targa file arrive on the request channel (data_byte_i,
// end_of_stream_i) under in_valid_i / in_stall_o; a request is taken at a
// rising edge with in_valid_i high and in_stall_o low. Each request yields
// zero or one result on the result channel (out_valid_o / out_stall_i):
// header information, one pixel with a repeat count, or an error code.
// Each result is registered at the edge that takes its request. One
// request is taken per cycle while in_stall_o is low; all the work
// for a byte is one short pass of logic between the decoder state
// and the result register, the widest piece being the 16 by 16
// multiply that forms the pixel total at the last header byte.
// A result that waits behind a stalled receiver sits in the output
// register while a skid register takes the next one, so requests keep
// flowing; only when both are full is in_stall_o raised, and it drops the
// cycle after the receiver takes a result. Results are never lost or
// duplicated while stalled. Reset puts the decoder back to waiting for a
// header with one component per pixel and empties both result registers.
// end_of_stream_i returns the decoder to the header phase from any state.
module tga_image_decoder
  import tga_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [31:0] pixel_word_o,
  output logic [7:0]  repeat_count_o,
  output logic [15:0] image_width_o,
  output logic [15:0] image_height_o,
  output logic [2:0]  component_count_o,
  output logic        last_pixel_o
);

  // Decoder state.
  phase_e              phase_q, phase_d;
  logic [HdrIdxW-1:0]  header_index_q, header_index_d;
  logic [7:0]          id_skip_q, id_skip_d;
  logic [31:0]         pixels_left_q, pixels_left_d;
  logic [7:0]          packet_left_q, packet_left_d;
  logic                packet_is_run_q, packet_is_run_d;
  logic [1:0]          comp_index_q, comp_index_d;
  logic [31:0]         pixel_hold_q, pixel_hold_d;
  logic [2:0]          components_q, components_d;

  // Header bytes that are needed later. They are always written before
  // they are read, so they carry no reset.
  logic [7:0] hdr_id_len_q, hdr_id_len_d;
  logic [7:0] hdr_type_q, hdr_type_d;
  logic [7:0] hdr_width_lo_q, hdr_width_lo_d;
  logic [7:0] hdr_width_hi_q, hdr_width_hi_d;
  logic [7:0] hdr_height_lo_q, hdr_height_lo_d;
  logic [7:0] hdr_height_hi_q, hdr_height_hi_d;
  logic [7:0] hdr_depth_q, hdr_depth_d;

  // Result buffering.
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic    in_accept;
  logic    res_valid;
  result_t res;

  // Shared datapath terms.
  logic [15:0] hdr_width, hdr_height;
  logic [31:0] pixel_total;
  logic        type_ok, depth_ok;
  logic [31:0] hold_merged, pixel_word;
  logic        pixel_done;
  logic [7:0]  pkt_count;
  logic        pkt_overrun;
  logic [7:0]  run_repeat;
  logic [31:0] raw_left, pkt_left_after;
  logic        truncated;

  // The skid register only fills while the output register is stalled, so
  // requests are held off exactly while it is occupied.
  assign in_stall_o = skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Header decode. The multiply result is only used after it has been
  // stored in pixels_left_q.
  assign hdr_width   = {hdr_width_hi_q, hdr_width_lo_q};
  assign hdr_height  = {hdr_height_hi_q, hdr_height_lo_q};
  assign pixel_total = hdr_width * hdr_height;
  assign type_ok     = (hdr_type_q == TYPE_TRUE_COLOUR) || (hdr_type_q == TYPE_MONO) ||
                       (hdr_type_q == TYPE_RLE_COLOUR);
  assign depth_ok    = (hdr_depth_q == DEPTH_8) || (hdr_depth_q == DEPTH_24) ||
                       (hdr_depth_q == DEPTH_32);

  // Pixel assembly: the byte goes into the lane chosen by the component
  // index; with three or four components the first and third bytes swap so
  // that blue-green-red becomes red-green-blue.
  assign hold_merged = pixel_hold_q | ({24'd0, data_byte_i} << {comp_index_q, 3'b000});
  assign pixel_done  = ({1'b0, comp_index_q} + 3'd1) >= components_q;
  assign pixel_word  = (components_q >= 3'd3) ?
                       {hold_merged[31:24], hold_merged[7:0],
                        hold_merged[15:8], hold_merged[23:16]} : hold_merged;

  // Packets.
  assign pkt_count   = (data_byte_i & PKT_COUNT_MASK) + 8'd1;
  assign pkt_overrun = {24'd0, pkt_count} > pixels_left_q;
  assign run_repeat  = packet_is_run_q ? packet_left_q : 8'd1;
  assign raw_left    = (pixels_left_q != 32'd0) ? pixels_left_q - 32'd1 : 32'd0;
  assign pkt_left_after = ({24'd0, run_repeat} > pixels_left_q) ? 32'd0 :
                          pixels_left_q - {24'd0, run_repeat};

  // A stream that ends part way through a header, the ID field or the
  // pixel data is reported as truncated.
  assign truncated = ((phase_q == PH_HEADER) && (header_index_q != '0)) ||
                     (phase_q == PH_IDSKIP) || (phase_q == PH_RAW) ||
                     (phase_q == PH_PKTHDR) || (phase_q == PH_PKTDATA);

  // Next state of the decoder.
  always_comb begin : next_state
    phase_d         = phase_q;
    header_index_d  = header_index_q;
    id_skip_d       = id_skip_q;
    pixels_left_d   = pixels_left_q;
    packet_left_d   = packet_left_q;
    packet_is_run_d = packet_is_run_q;
    comp_index_d    = comp_index_q;
    pixel_hold_d    = pixel_hold_q;
    components_d    = components_q;
    hdr_id_len_d    = hdr_id_len_q;
    hdr_type_d      = hdr_type_q;
    hdr_width_lo_d  = hdr_width_lo_q;
    hdr_width_hi_d  = hdr_width_hi_q;
    hdr_height_lo_d = hdr_height_lo_q;
    hdr_height_hi_d = hdr_height_hi_q;
    hdr_depth_d     = hdr_depth_q;

    if (in_accept) begin
      if (end_of_stream_i) begin
        phase_d         = PH_HEADER;
        header_index_d  = '0;
        id_skip_d       = 8'd0;
        pixels_left_d   = 32'd0;
        packet_left_d   = 8'd0;
        packet_is_run_d = 1'b0;
        comp_index_d    = 2'd0;
        pixel_hold_d    = 32'd0;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            case (header_index_q)
              HDR_ID_LEN:    hdr_id_len_d    = data_byte_i;
              HDR_TYPE:      hdr_type_d      = data_byte_i;
              HDR_WIDTH_LO:  hdr_width_lo_d  = data_byte_i;
              HDR_WIDTH_HI:  hdr_width_hi_d  = data_byte_i;
              HDR_HEIGHT_LO: hdr_height_lo_d = data_byte_i;
              HDR_HEIGHT_HI: hdr_height_hi_d = data_byte_i;
              HDR_DEPTH:     hdr_depth_d     = data_byte_i;
              default: ;
            endcase
            if (header_index_q == HDR_LAST) begin
              header_index_d = '0;
              if (!type_ok || !depth_ok) begin
                phase_d = PH_ERROR;
              end else begin
                components_d    = hdr_depth_q[5:3];
                pixels_left_d   = pixel_total;
                id_skip_d       = hdr_id_len_q;
                comp_index_d    = 2'd0;
                pixel_hold_d    = 32'd0;
                packet_left_d   = 8'd0;
                packet_is_run_d = 1'b0;
                if (hdr_id_len_q != 8'd0) begin
                  phase_d = PH_IDSKIP;
                end else if (hdr_width == 16'd0 || hdr_height == 16'd0) begin
                  phase_d = PH_DONE;
                end else if (hdr_type_q == TYPE_RLE_COLOUR) begin
                  phase_d = PH_PKTHDR;
                end else begin
                  phase_d = PH_RAW;
                end
              end
            end else begin
              header_index_d = header_index_q + HdrIdxW'(1);
            end
          end
          PH_IDSKIP: begin
            id_skip_d = id_skip_q - 8'd1;
            if (id_skip_q == 8'd1) begin
              if (pixels_left_q == 32'd0) begin
                phase_d = PH_DONE;
              end else if (hdr_type_q == TYPE_RLE_COLOUR) begin
                phase_d = PH_PKTHDR;
              end else begin
                phase_d = PH_RAW;
              end
            end
          end
          PH_RAW: begin
            if (pixel_done) begin
              pixel_hold_d  = 32'd0;
              comp_index_d  = 2'd0;
              pixels_left_d = raw_left;
              if (raw_left == 32'd0) begin
                phase_d = PH_DONE;
              end
            end else begin
              pixel_hold_d = hold_merged;
              comp_index_d = comp_index_q + 2'd1;
            end
          end
          PH_PKTHDR: begin
            if (pkt_overrun) begin
              phase_d = PH_ERROR;
            end else begin
              packet_left_d   = pkt_count;
              packet_is_run_d = (data_byte_i & PKT_RUN_MASK) != 8'd0;
              comp_index_d    = 2'd0;
              pixel_hold_d    = 32'd0;
              phase_d         = PH_PKTDATA;
            end
          end
          PH_PKTDATA: begin
            if (pixel_done) begin
              pixel_hold_d  = 32'd0;
              comp_index_d  = 2'd0;
              pixels_left_d = pkt_left_after;
              if (packet_is_run_q) begin
                packet_left_d = 8'd0;
              end else if (packet_left_q != 8'd0) begin
                packet_left_d = packet_left_q - 8'd1;
              end
              if (pkt_left_after == 32'd0) begin
                phase_d = PH_DONE;
              end else if (packet_is_run_q || packet_left_q <= 8'd1) begin
                phase_d = PH_PKTHDR;
              end
            end else begin
              pixel_hold_d = hold_merged;
              comp_index_d = comp_index_q + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result of the current request.
  always_comb begin : result_gen
    res_valid           = 1'b0;
    res.kind            = KIND_HEADER;
    res.pixel_word      = 32'd0;
    res.repeat_count    = 8'd0;
    res.image_width     = 16'd0;
    res.image_height    = 16'd0;
    res.component_count = components_d;
    res.last_pixel      = 1'b0;

    if (in_accept) begin
      if (end_of_stream_i) begin
        res_valid = truncated;
        res.kind  = KIND_TRUNCATED;
      end else begin
        case (phase_q)
          PH_HEADER: begin
            if (header_index_q == HDR_LAST) begin
              res_valid = 1'b1;
              if (!type_ok) begin
                res.kind = KIND_BAD_TYPE;
              end else if (!depth_ok) begin
                res.kind = KIND_BAD_DEPTH;
              end else begin
                res.kind         = KIND_HEADER;
                res.image_width  = hdr_width;
                res.image_height = hdr_height;
              end
            end
          end
          PH_RAW: begin
            res_valid        = pixel_done;
            res.kind         = KIND_PIXEL;
            res.pixel_word   = pixel_word;
            res.repeat_count = 8'd1;
            res.last_pixel   = raw_left == 32'd0;
          end
          PH_PKTHDR: begin
            res_valid = pkt_overrun;
            res.kind  = KIND_OVERRUN;
          end
          PH_PKTDATA: begin
            res_valid        = pixel_done;
            res.kind         = KIND_PIXEL;
            res.pixel_word   = pixel_word;
            res.repeat_count = run_repeat;
            res.last_pixel   = pkt_left_after == 32'd0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register with a skid stage behind it. A new result goes straight
  // to the output register when that is free or being taken; otherwise it
  // parks in the skid register, which drains as soon as the receiver takes
  // the waiting result.
  always_comb begin : out_buffer
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (!out_stall_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_q || !out_stall_i) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_HEADER;
      header_index_q  <= '0;
      id_skip_q       <= 8'd0;
      pixels_left_q   <= 32'd0;
      packet_left_q   <= 8'd0;
      packet_is_run_q <= 1'b0;
      comp_index_q    <= 2'd0;
      pixel_hold_q    <= 32'd0;
      components_q    <= 3'd1;
      out_valid_q     <= 1'b0;
      skid_valid_q    <= 1'b0;
    end else begin
      phase_q         <= phase_d;
      header_index_q  <= header_index_d;
      id_skip_q       <= id_skip_d;
      pixels_left_q   <= pixels_left_d;
      packet_left_q   <= packet_left_d;
      packet_is_run_q <= packet_is_run_d;
      comp_index_q    <= comp_index_d;
      pixel_hold_q    <= pixel_hold_d;
      components_q    <= components_d;
      out_valid_q     <= out_valid_d;
      skid_valid_q    <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hdr_id_len_q    <= hdr_id_len_d;
    hdr_type_q      <= hdr_type_d;
    hdr_width_lo_q  <= hdr_width_lo_d;
    hdr_width_hi_q  <= hdr_width_hi_d;
    hdr_height_lo_q <= hdr_height_lo_d;
    hdr_height_hi_q <= hdr_height_hi_d;
    hdr_depth_q     <= hdr_depth_d;
    out_q           <= out_d;
    skid_q          <= skid_d;
  end

  assign out_valid_o       = out_valid_q;
  assign kind_o            = out_q.kind;
  assign pixel_word_o      = out_q.pixel_word;
  assign repeat_count_o    = out_q.repeat_count;
  assign image_width_o     = out_q.image_width;
  assign image_height_o    = out_q.image_height;
  assign component_count_o = out_q.component_count;
  assign last_pixel_o      = out_q.last_pixel;

`ifndef SYNTHESIS
  // The skid register is only ever filled behind a waiting output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result with the output register empty");

  // Packet data is only decoded while the packet still owes pixels.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PKTDATA) |-> (packet_left_q != 8'd0))
    else $error("packet data phase with an empty packet");

  // Pixel phases always owe at least one pixel to the image.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((phase_q == PH_RAW) || (phase_q == PH_PKTHDR) || (phase_q == PH_PKTDATA))
      |-> (pixels_left_q != 32'd0))
    else $error("pixel phase with no pixels left");

  // A completed image leaves the decoder in the done phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && res_valid && res.last_pixel) |=> (phase_q == PH_DONE))
    else $error("last pixel reported but image not complete");
`endif

endmodule
